@@ sv/ctt_pkg.sv @@
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared sizes, codes and control/status bundles for the connection timeout
// table.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

	// Table depth and derived index widths.
	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Field widths of one item.
	localparam int CMD_W    = 2;
	localparam int HANDLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int KA_W     = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;

	// Stream data widths, rounded up to whole bytes.
	localparam int IN_TDATA_W  = ((CMD_W + HANDLE_W + TIME_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((STATUS_W + SLOT_W + TIME_W + 1 + 7) / 8) * 8;

	// Keep-alive register reset value.
	localparam logic [KA_W-1:0] KEEP_ALIVE_RESET = KA_W'(5);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // latch a new item and restart the scan at entry 0
		logic step;      // advance the scan index by one
		logic capture;   // record the matching entry
		logic shift_wr;  // move the current entry down by one position
		logic finish;    // apply the final update and load the result register
	} ctt_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic empty;      // no valid entries
		logic hit;        // current entry matches the handle
		logic last;       // current entry is the last valid one
		logic shift_end;  // scan index has passed the last valid entry
		logic remove_go;  // item is a remove of a nonzero handle
		logic out_busy;   // result register holds an item not yet taken
	} ctt_stat_t;

endpackage

`default_nettype wire

@@ sv/ctt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctt_ctrl
// Sequencer for one request: scan the table, shift on remove, then hand the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ctt_pkg::ctt_stat_t sts,
	output ctt_pkg::ctt_cmd_t       ctl
);
	import ctt_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = sts.empty ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					ctl.capture = 1'b1;
					if (sts.remove_go) begin
						ctl.step = 1'b1;
						state_d  = S_SHIFT;
					end else begin
						state_d = S_DONE;
					end
				end else if (sts.last) begin
					state_d = S_DONE;
				end else begin
					ctl.step = 1'b1;
				end
			end
			S_SHIFT: begin
				if (sts.shift_end) begin
					state_d = S_DONE;
				end else begin
					ctl.shift_wr = 1'b1;
					ctl.step     = 1'b1;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/ctt_datapath.sv @@
// ----------------------------------------------------------------------------
// ctt_datapath
// Handle and expiry memories, entry count, scan index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [ctt_pkg::CMD_W-1:0]         in_cmd,
	input  wire logic [ctt_pkg::HANDLE_W-1:0]      in_handle,
	input  wire logic [ctt_pkg::TIME_W-1:0]        in_now,
	input  wire logic [ctt_pkg::KA_W-1:0]          keep_alive,
	input  wire ctt_pkg::ctt_cmd_t                 ctl,
	output ctt_pkg::ctt_stat_t                     sts,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [ctt_pkg::STATUS_W-1:0]           out_status,
	output logic [ctt_pkg::SLOT_W-1:0]             out_slot,
	output logic [ctt_pkg::TIME_W-1:0]             out_expiry,
	output logic                                   out_expired
);
	import ctt_pkg::*;

	// Latched request.
	logic [CMD_W-1:0]    cmd_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [TIME_W-1:0]   now_q;

	// Table state.
	logic [HANDLE_W-1:0] handle_mem [MAX_ENTRIES];
	logic [TIME_W-1:0]   expiry_mem [MAX_ENTRIES];
	logic [CNT_W-1:0]    count_q;

	// Scan state.
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    idx_d;
	logic [HANDLE_W-1:0] handle_rd_q;
	logic [TIME_W-1:0]   expiry_rd_q;
	logic                found_q;
	logic [IDX_W-1:0]    pos_q;
	logic [TIME_W-1:0]   hit_expiry_q;

	// Final update terms.
	logic                is_full;
	logic                insert_ok;
	logic                remove_ok;
	logic                refresh_ok;
	logic [TIME_W-1:0]   refresh_val;

	// Memory write port.
	logic                h_we;
	logic                e_we;
	logic [IDX_W-1:0]    h_waddr;
	logic [IDX_W-1:0]    e_waddr;
	logic [HANDLE_W-1:0] h_wdata;
	logic [TIME_W-1:0]   e_wdata;

	// Result register.
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [TIME_W-1:0]   expiry_q;
	logic                expired_q;
	logic [STATUS_W-1:0] status_d;
	logic [SLOT_W-1:0]   slot_d;
	logic [TIME_W-1:0]   expiry_d;
	logic                expired_d;

	// Request latch.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= in_cmd;
			handle_q <= in_handle;
			now_q    <= in_now;
		end
	end

	// Scan index: the read data always belongs to idx_q.
	always_comb begin
		idx_d = idx_q;
		if (ctl.load) begin
			idx_d = '0;
		end else if (ctl.step) begin
			idx_d = idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			idx_q <= idx_d;
		end
	end

	// Status toward the controller.
	assign is_full       = (count_q == CNT_W'(MAX_ENTRIES));
	assign sts.empty     = (count_q == '0);
	assign sts.hit       = (handle_rd_q == handle_q);
	assign sts.last      = (idx_q == count_q - 1'b1);
	assign sts.shift_end = (idx_q >= count_q);
	assign sts.remove_go = (cmd_q == CMD_REMOVE) && (handle_q != '0);
	assign sts.out_busy  = out_valid_q && !out_ready;

	// Match capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.load) begin
			found_q <= 1'b0;
		end else if (ctl.capture) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			pos_q        <= idx_q[IDX_W-1:0];
			hit_expiry_q <= expiry_rd_q;
		end
	end

	// Final update conditions.
	assign insert_ok   = (cmd_q == CMD_INSERT) && !found_q && !is_full;
	assign remove_ok   = sts.remove_go && found_q;
	assign refresh_ok  = (cmd_q == CMD_REFRESH) && found_q;
	assign refresh_val = now_q + TIME_W'(keep_alive);

	// Write port: shift moves an entry down, finish appends or refreshes.
	always_comb begin
		h_we    = 1'b0;
		e_we    = 1'b0;
		h_waddr = count_q[IDX_W-1:0];
		e_waddr = count_q[IDX_W-1:0];
		h_wdata = handle_q;
		e_wdata = '0;
		if (ctl.shift_wr) begin
			h_we    = 1'b1;
			e_we    = 1'b1;
			h_waddr = idx_q[IDX_W-1:0] - 1'b1;
			e_waddr = idx_q[IDX_W-1:0] - 1'b1;
			h_wdata = handle_rd_q;
			e_wdata = expiry_rd_q;
		end else if (ctl.finish && insert_ok) begin
			h_we = 1'b1;
			e_we = 1'b1;
		end else if (ctl.finish && refresh_ok) begin
			e_we    = 1'b1;
			e_waddr = pos_q;
			e_wdata = refresh_val;
		end
	end

	// Memories with registered read at the next scan index.
	always_ff @(posedge clk) begin
		if (h_we) begin
			handle_mem[h_waddr] <= h_wdata;
		end
		handle_rd_q <= handle_mem[idx_d[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			expiry_mem[e_waddr] <= e_wdata;
		end
		expiry_rd_q <= expiry_mem[idx_d[IDX_W-1:0]];
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.finish && insert_ok) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.finish && remove_ok) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Result fields.
	always_comb begin
		status_d  = ST_MISSING;
		slot_d    = '0;
		expiry_d  = '0;
		expired_d = 1'b0;
		case (cmd_q)
			CMD_INSERT: begin
				if (found_q) begin
					status_d = ST_PRESENT;
					slot_d   = SLOT_W'(pos_q);
				end else if (is_full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					slot_d   = SLOT_W'(count_q);
				end
			end
			CMD_REMOVE: begin
				if (remove_ok) begin
					status_d = ST_OK;
					slot_d   = SLOT_W'(pos_q);
				end
			end
			CMD_LOOKUP: begin
				if (found_q) begin
					status_d  = ST_OK;
					slot_d    = SLOT_W'(pos_q);
					expiry_d  = hit_expiry_q;
					expired_d = (hit_expiry_q != '0) && (hit_expiry_q < now_q);
				end
			end
			default: begin
				if (refresh_ok) begin
					status_d = ST_OK;
					slot_d   = SLOT_W'(pos_q);
					expiry_d = refresh_val;
				end
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status_q  <= status_d;
			slot_q    <= slot_d;
			expiry_q  <= expiry_d;
			expired_q <= expired_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = status_q;
	assign out_slot    = slot_q;
	assign out_expiry  = expiry_q;
	assign out_expired = expired_q;

	// The count never exceeds the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table depth");

	// A shift only moves a valid entry that has a slot below it.
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift_wr |-> (idx_q != '0) && (idx_q < count_q))
		else $error("shift outside the valid entries");

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten");

	// Every finished request presents a result.
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> out_valid_q)
		else $error("finished request produced no result");

endmodule

`default_nettype wire

@@ sv/connection_timeout_table.sv @@
// ----------------------------------------------------------------------------
// connection_timeout_table
// Packed table of connection handles with expiry times: insert, remove with
// gap closing, expiry lookup and keep-alive refresh.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Handshake                 Payload
// s_axis       in         s_axis_tvalid/tready      cmd, handle, now
// m_axis       out        m_axis_tvalid/tready      status, slot, expiry, expired
// apb          in         psel/penable/pready       keep_alive_seconds at 0x0
//
// One request is handled at a time: the entries are compared in order, as the
// memories are read one entry per cycle. A remove that finds its entry then
// moves each later entry down by one position.
// The result waits in an output register; a request stalls before its result
// is loaded while the previous result has not been taken.
// Reset empties the table and sets keep_alive_seconds to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_timeout_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// cmd [1:0], handle [17:2], now [49:18], zero fill above
	input  wire logic [ctt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// status [1:0], slot [7:2], expiry [39:8], expired [40], zero fill above
	output logic [ctt_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);
	import ctt_pkg::*;

	logic [KA_W-1:0]     keep_alive_q;
	logic                reg0_sel;
	ctt_cmd_t            ctl;
	ctt_stat_t           sts;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_slot;
	logic [TIME_W-1:0]   res_expiry;
	logic                res_expired;

	// Configuration register.
	assign pready   = 1'b1;
	assign reg0_sel = (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_alive_q <= KEEP_ALIVE_RESET;
		end else if (psel && penable && pwrite && pready && reg0_sel) begin
			keep_alive_q <= pwdata[KA_W-1:0];
		end
	end

	assign prdata = reg0_sel ? {{(32 - KA_W){1'b0}}, keep_alive_q} : '0;

	// Request sequencer.
	ctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Table and result datapath.
	ctt_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_cmd      (s_axis_tdata[CMD_W-1:0]),
		.in_handle   (s_axis_tdata[CMD_W +: HANDLE_W]),
		.in_now      (s_axis_tdata[CMD_W + HANDLE_W +: TIME_W]),
		.keep_alive  (keep_alive_q),
		.ctl         (ctl),
		.sts         (sts),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_status  (res_status),
		.out_slot    (res_slot),
		.out_expiry  (res_expiry),
		.out_expired (res_expired)
	);

	// Result packing.
	assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W - SLOT_W - TIME_W - 1){1'b0}},
		res_expired, res_expiry, res_slot, res_status};

endmodule

`default_nettype wire

@@ tb/tb_connection_timeout_table.sv @@
// ----------------------------------------------------------------------------
// tb_connection_timeout_table
// Self-checking bench for the connection timeout table. Requests go in on the
// input stream with random gaps, results are taken on the output stream with
// random back-pressure, and each result is compared with the response of a
// behavioral copy of the table kept inside the bench. The keep-alive register
// is written and read back over the APB port between phases.
// ----------------------------------------------------------------------------

module tb_connection_timeout_table;
	timeunit 1ns;
	timeprecision 1ps;

	import ctt_pkg::*;

	// Register addresses on the APB port.
	localparam logic [2:0] KA_ADDR     = 3'd0;
	localparam logic [2:0] UNUSED_ADDR = 3'd4;

	// Cycles without any stream transfer before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Quiet cycles after the last result, longer than one full scan and shift.
	localparam int TAIL_CYCLES    = 150;
	localparam int POOL_SIZE      = 96;

	// One result item, laid out as on m_axis_tdata from the highest bit down.
	typedef struct packed {
		logic                expired;
		logic [TIME_W-1:0]   expiry;
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
	} result_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic                   psel          = 1'b0;
	logic                   penable       = 1'b0;
	logic                   pwrite        = 1'b0;
	logic [2:0]             paddr         = '0;
	logic [31:0]            pwdata        = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// Bench copy of the table contents and the keep-alive setting.
	logic [HANDLE_W-1:0] tbl_handle [MAX_ENTRIES];
	logic [TIME_W-1:0]   tbl_expiry [MAX_ENTRIES];
	int                  tbl_count;
	logic [KA_W-1:0]     keep_alive;

	result_t             pending_results [$];
	logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];
	logic [TIME_W-1:0]   cur_time;
	bit                  no_idle = 1'b0;
	int                  err_count = 0;
	int                  stall_left = 0;
	int                  quiet_cycles = 0;

	connection_timeout_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic log_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endtask

	// Applies one request to the bench table and returns the result it must give.
	function automatic result_t table_apply(input logic [CMD_W-1:0] cmd,
			input logic [HANDLE_W-1:0] handle, input logic [TIME_W-1:0] req_time);
		result_t r;
		int      pos;
		int      i;
		r = '0;
		r.status = ST_MISSING;
		pos = -1;
		for (i = 0; i < tbl_count; i++) begin
			if (pos < 0 && tbl_handle[i] == handle)
				pos = i;
		end
		case (cmd)
			CMD_INSERT: begin
				// The duplicate check wins over the full-table check.
				if (pos >= 0) begin
					r.status = ST_PRESENT;
					r.slot   = SLOT_W'(pos);
				end else if (tbl_count >= MAX_ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					tbl_handle[tbl_count] = handle;
					tbl_expiry[tbl_count] = '0;
					r.slot   = SLOT_W'(tbl_count);
					r.status = ST_OK;
					tbl_count++;
				end
			end
			CMD_REMOVE: begin
				// Handle zero can never be removed; otherwise close the gap.
				if (handle != '0 && pos >= 0) begin
					for (i = pos + 1; i < tbl_count; i++) begin
						tbl_handle[i-1] = tbl_handle[i];
						tbl_expiry[i-1] = tbl_expiry[i];
					end
					tbl_count--;
					r.slot   = SLOT_W'(pos);
					r.status = ST_OK;
				end
			end
			CMD_LOOKUP: begin
				if (pos >= 0) begin
					r.expiry  = tbl_expiry[pos];
					r.expired = (r.expiry != '0) && (r.expiry < req_time);
					r.slot    = SLOT_W'(pos);
					r.status  = ST_OK;
				end
			end
			default: begin
				// Refresh wraps modulo 2^32.
				if (pos >= 0) begin
					r.expiry        = req_time + TIME_W'(keep_alive);
					tbl_expiry[pos] = r.expiry;
					r.slot          = SLOT_W'(pos);
					r.status        = ST_OK;
				end
			end
		endcase
		return r;
	endfunction

	// Offers one request and records its expected result once it is taken.
	task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
			input logic [TIME_W-1:0] req_time);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= IN_TDATA_W'({req_time, handle, cmd});
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.insert(pending_results.size(), table_apply(cmd, handle, req_time));
	endtask

	// Stops offering items and waits until every result is back.
	task automatic wait_idle();
		if (s_axis_tvalid)
			s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == KA_ADDR)
			keep_alive = data[KA_W-1:0];
	endtask

	task automatic cfg_expect(input logic [2:0] addr, input logic [KA_W-1:0] want);
		logic [31:0] data;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (data[KA_W-1:0] !== want)
			log_error($sformatf("register read at %0d: expected %h, got %h", addr, want,
				data[KA_W-1:0]));
	endtask

	// Output side: take results under random back-pressure and check them in order.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
			if (pending_results.size() == 0) begin
				log_error($sformatf("unexpected result: status %0d slot %0d expiry %h expired %0d",
					got.status, got.slot, got.expiry, got.expired));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.slot !== want.slot ||
						got.expiry !== want.expiry || got.expired !== want.expired)
					log_error($sformatf({"result mismatch: expected status %0d slot %0d ",
						"expiry %h expired %0d, got status %0d slot %0d expiry %h expired %0d"},
						want.status, want.slot, want.expiry, want.expired,
						got.status, got.slot, got.expiry, got.expired));
			end
		end
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// Watchdog on stream progress.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_connection_timeout_table: errors");
			$finish;
		end
	end

	// Empty table, duplicates, handle zero, missing handles, expiry edges, wrap.
	task automatic test_basic_commands();
		send_req(CMD_LOOKUP,  16'h0000, 32'h0000_0000);
		send_req(CMD_REMOVE,  16'h0000, 32'h0000_0000);
		send_req(CMD_REFRESH, 16'hFFFF, 32'hFFFF_FFFF);
		send_req(CMD_INSERT,  16'h0000, 32'h0000_0000);
		send_req(CMD_INSERT,  16'hFFFF, 32'd100);
		send_req(CMD_INSERT,  16'hFFFF, 32'd100);
		send_req(CMD_INSERT,  16'h0000, 32'd100);
		send_req(CMD_LOOKUP,  16'hFFFF, 32'd100);
		send_req(CMD_REFRESH, 16'hFFFF, 32'd1000);
		send_req(CMD_LOOKUP,  16'hFFFF, 32'd1005);
		send_req(CMD_LOOKUP,  16'hFFFF, 32'd1006);
		send_req(CMD_REFRESH, 16'h0000, 32'hFFFF_FFFF);
		send_req(CMD_LOOKUP,  16'h0000, 32'hFFFF_FFFF);
		send_req(CMD_INSERT,  16'h5A5A, 32'd2000);
		send_req(CMD_REMOVE,  16'h0000, 32'd2000);
		send_req(CMD_REMOVE,  16'hFFFF, 32'd2000);
		send_req(CMD_LOOKUP,  16'h5A5A, 32'd2000);
		send_req(CMD_REMOVE,  16'hFFFF, 32'd2001);
		send_req(CMD_REFRESH, 16'hFFFF, 32'd2001);
		send_req(CMD_LOOKUP,  16'hA5A5, 32'd2001);
		send_req(CMD_REMOVE,  16'h5A5A, 32'd2002);
		send_req(CMD_INSERT,  16'h5A5A, 32'd2002);
		wait_idle();
	endtask

	// Fill the table, overflow it, then remove at the ends and the middle.
	task automatic test_full_table();
		int k;
		k = 0;
		while (tbl_count < MAX_ENTRIES) begin
			send_req(CMD_INSERT, 16'h0100 + HANDLE_W'(k), cur_time);
			k++;
		end
		send_req(CMD_INSERT,  16'hBEEF, cur_time);
		send_req(CMD_INSERT,  tbl_handle[MAX_ENTRIES-1], cur_time);
		send_req(CMD_INSERT,  tbl_handle[0], cur_time);
		send_req(CMD_REFRESH, tbl_handle[MAX_ENTRIES-1], cur_time);
		send_req(CMD_LOOKUP,  tbl_handle[MAX_ENTRIES-1], cur_time + 32'd9);
		send_req(CMD_REMOVE,  tbl_handle[0], cur_time);
		send_req(CMD_REMOVE,  tbl_handle[1], cur_time);
		send_req(CMD_REMOVE,  tbl_handle[31], cur_time);
		send_req(CMD_REMOVE,  tbl_handle[tbl_count-1], cur_time);
		send_req(CMD_LOOKUP,  tbl_handle[tbl_count-1], cur_time);
		send_req(CMD_LOOKUP,  tbl_handle[31], cur_time);
		send_req(CMD_INSERT,  16'hBEEF, cur_time);
		while (tbl_count < MAX_ENTRIES) begin
			send_req(CMD_INSERT, 16'h0100 + HANDLE_W'(k), cur_time);
			k++;
		end
		send_req(CMD_INSERT, 16'hC0DE, cur_time);
		wait_idle();
	endtask

	// Keep-alive reset value, both extremes, readback, unknown address, wrap past zero.
	task automatic test_keep_alive_register();
		cfg_expect(KA_ADDR, KEEP_ALIVE_RESET);
		cfg_write(KA_ADDR, {16'hA5C3, 16'h0000});
		cfg_expect(KA_ADDR, 16'h0000);
		send_req(CMD_REFRESH, tbl_handle[1], 32'd500);
		send_req(CMD_LOOKUP,  tbl_handle[1], 32'd501);
		send_req(CMD_LOOKUP,  tbl_handle[1], 32'd500);
		wait_idle();
		cfg_write(KA_ADDR, 32'h0000_FFFF);
		cfg_write(UNUSED_ADDR, $urandom);
		cfg_expect(KA_ADDR, 16'hFFFF);
		send_req(CMD_REFRESH, tbl_handle[2], 32'hFFFF_0001);
		send_req(CMD_LOOKUP,  tbl_handle[2], 32'hFFFF_FFFF);
		send_req(CMD_REFRESH, tbl_handle[3], 32'hFFFF_0002);
		send_req(CMD_LOOKUP,  tbl_handle[3], 32'd2);
		wait_idle();
		cfg_write(KA_ADDR, {16'h5A3C, KEEP_ALIVE_RESET});
	endtask

	// Segments of random traffic, each with its own keep-alive and command mix.
	task automatic test_random_traffic();
		int                  seg;
		int                  n;
		int                  mode;
		int                  r;
		logic [CMD_W-1:0]    cmd;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   req_time;
		logic [31:0]         ka;
		for (seg = 0; seg < 10; seg++) begin
			wait_idle();
			r = $urandom_range(0, 9);
			if (r < 6)
				ka = {16'($urandom_range(0, 65535)), 16'h0000} | $urandom_range(0, 20);
			else if (r == 6)
				ka = {16'($urandom_range(0, 65535)), 16'h0000};
			else if (r == 7)
				ka = {16'($urandom_range(0, 65535)), 16'hFFFF};
			else
				ka = $urandom;
			cfg_write(KA_ADDR, ka);
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				cur_time = 32'hFFFF_FFFF - $urandom_range(0, 400);
			// 0 fills the table, 1 drains it, 2 mixes.
			mode = (seg < 3) ? seg : $urandom_range(0, 2);
			for (n = 0; n < 145; n++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0:       cmd = (r < 60) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
						(r < 85) ? CMD_LOOKUP : CMD_REFRESH;
					1:       cmd = (r < 10) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
						(r < 85) ? CMD_LOOKUP : CMD_REFRESH;
					default: cmd = (r < 30) ? CMD_INSERT : (r < 55) ? CMD_REMOVE :
						(r < 80) ? CMD_LOOKUP : CMD_REFRESH;
				endcase
				// Mostly handles that are in the table or in the shared pool.
				r = $urandom_range(0, 9);
				if (cmd != CMD_INSERT && tbl_count > 0 && r < 7)
					handle = tbl_handle[$urandom_range(0, tbl_count - 1)];
				else if (r < 9)
					handle = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					handle = HANDLE_W'($urandom);
				if ($urandom_range(0, 19) == 0) begin
					req_time = $urandom;
				end else begin
					cur_time = cur_time + $urandom_range(0, 6);
					req_time = cur_time;
				end
				send_req(cmd, handle, req_time);
			end
		end
		no_idle = 1'b0;
		wait_idle();
	endtask

	initial begin
		int i;
		tbl_count  = 0;
		keep_alive = KEEP_ALIVE_RESET;
		cur_time   = 32'd3000;
		handle_pool[0] = 16'h0000;
		handle_pool[1] = 16'hFFFF;
		for (i = 2; i < POOL_SIZE; i++)
			handle_pool[i] = HANDLE_W'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_commands();
		test_full_table();
		test_keep_alive_register();
		test_random_traffic();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_connection_timeout_table: clean");
		else
			$display("tb_connection_timeout_table: errors");
		$finish;
	end

endmodule

@@ files.f @@
sv/ctt_pkg.sv
sv/ctt_ctrl.sv
sv/ctt_datapath.sv
sv/connection_timeout_table.sv
tb/tb_connection_timeout_table.sv
